>>> rtl/msa_pkg.sv
// Shared types and constants for the mesh surface area accumulator.
package msa_pkg;

    // Item kinds carried on req_type.
    localparam logic REQ_VERTEX   = 1'b0;
    localparam logic REQ_TRIANGLE = 1'b1;

    // Fixed widths of the index and per-triangle result fields.
    localparam int SLOT_BITS = 12;
    localparam int TRI_BITS  = 26;
    localparam logic [TRI_BITS-1:0] TRI_MAX = {TRI_BITS{1'b1}};

    // Status of the square-root unit as seen by the sequencer.
    typedef struct packed {
        logic busy;
        logic done;
    } sqrt_stat_t;

endpackage

>>> rtl/msa_isqrt.sv
// Bit-serial integer square root, one result bit per clock.
module msa_isqrt #(
    parameter int OUT_BITS = 27
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [2*OUT_BITS-1:0]   radicand,
    output msa_pkg::sqrt_stat_t     stat,
    output logic [OUT_BITS-1:0]     root
);
    import msa_pkg::*;

    localparam int IN_BITS = 2 * OUT_BITS;
    localparam int CW      = $clog2(OUT_BITS + 1);

    logic [IN_BITS-1:0]  rad_reg;
    logic [OUT_BITS+1:0] rem_reg;
    logic [OUT_BITS-1:0] root_reg;
    logic [CW-1:0]       cnt_reg;
    logic                busy_reg;
    logic                done_reg;

    logic [OUT_BITS+1:0] rem_shift;
    logic [OUT_BITS+1:0] trial;
    logic                take;

    // One restoring step: bring down two radicand bits and try appending a one.
    always_comb
    begin
        rem_shift = {rem_reg[OUT_BITS-1:0], rad_reg[IN_BITS-1 -: 2]};
        trial     = {root_reg, 2'b01};
        take      = (rem_shift >= trial);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(OUT_BITS);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg <= {rad_reg[IN_BITS-3:0], 2'b00};
            if (take)
            begin
                rem_reg  <= rem_shift - trial;
                root_reg <= {root_reg[OUT_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= rem_shift;
                root_reg <= {root_reg[OUT_BITS-2:0], 1'b0};
            end
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign root      = root_reg;

endmodule

>>> rtl/mesh_surface_area_accumulator.sv
// Top level of the mesh surface area accumulator: vertex store and triangle sequencer.
//
//  Channel   Handshake            Fields
//  --------  -------------------  -------------------------------------------------
//  request   start / busy         req_type, vertex_slot, coord_x/y/z, corner_a/b/c,
//                                 restart
//  result    done (one-cycle)     tri_double_area, total_double_area, overflowed
//
// A vertex write is stored at the accepting edge; its result strobes on the next
// cycle and busy never rises, so vertex items can arrive every cycle.
// A triangle passes from accept to result through three reads of the
// single-port vertex memory, five arithmetic stages, then the square-root unit,
// which produces one root bit per cycle.
// Reset clears the running total and the flag; the vertex store is not cleared.
// The receiver cannot stall: each result is shown for exactly one cycle.
module mesh_surface_area_accumulator #(
    parameter int VERTEX_DEPTH = 4096,
    parameter int COORD_BITS   = 12,
    parameter int TOTAL_BITS   = 48
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic                            req_type,
    input  logic [msa_pkg::SLOT_BITS-1:0]   vertex_slot,
    input  logic signed [COORD_BITS-1:0]    coord_x,
    input  logic signed [COORD_BITS-1:0]    coord_y,
    input  logic signed [COORD_BITS-1:0]    coord_z,
    input  logic [msa_pkg::SLOT_BITS-1:0]   corner_a,
    input  logic [msa_pkg::SLOT_BITS-1:0]   corner_b,
    input  logic [msa_pkg::SLOT_BITS-1:0]   corner_c,
    input  logic                            restart,
    output logic                            done,
    output logic [msa_pkg::TRI_BITS-1:0]    tri_double_area,
    output logic [TOTAL_BITS-1:0]           total_double_area,
    output logic                            overflowed
);
    import msa_pkg::*;

    // Widths that follow from the coordinate size.
    localparam int AW        = (VERTEX_DEPTH > 1) ? $clog2(VERTEX_DEPTH) : 1;
    localparam int C         = COORD_BITS;
    localparam int DW        = 3 * C;
    localparam int DIFF_BITS = C + 1;
    localparam int PROD_BITS = 2 * C + 2;
    localparam int CRS_BITS  = 2 * C + 3;
    localparam int MAG_BITS  = 2 * C + 2;
    localparam int SQ_BITS   = 2 * MAG_BITS;
    localparam int ROOT_BITS = 2 * C + 3;
    localparam int RAD_BITS  = 2 * ROOT_BITS;
    localparam int ACC_BITS  = ((TOTAL_BITS > ROOT_BITS) ? TOTAL_BITS : ROOT_BITS) + 1;
    localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = {TOTAL_BITS{1'b1}};

    // Sequencer states.
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_RDA   = 4'd1;
    localparam logic [3:0] S_RDB   = 4'd2;
    localparam logic [3:0] S_RDC   = 4'd3;
    localparam logic [3:0] S_DIFF  = 4'd4;
    localparam logic [3:0] S_MUL   = 4'd5;
    localparam logic [3:0] S_CROSS = 4'd6;
    localparam logic [3:0] S_SQ    = 4'd7;
    localparam logic [3:0] S_SUM   = 4'd8;
    localparam logic [3:0] S_ROOT  = 4'd9;

    logic [3:0] state_reg, state_next;

    logic accept;
    logic slot_ok;

    // Vertex store: one word per vertex holding {x, y, z}.
    logic [DW-1:0] vstore [VERTEX_DEPTH];
    logic [AW-1:0] rd_addr;
    logic [DW-1:0] rd_data_reg;

    // Captured triangle request.
    logic [AW-1:0] ca_reg, cb_reg, cc_reg;
    logic          ok_a_reg, ok_b_reg, ok_c_reg;
    logic          restart_reg;

    // Datapath stage registers.
    logic [DW-1:0]                va_reg, vb_reg;
    logic [DW-1:0]                vc;
    logic signed [DIFF_BITS-1:0]  u_reg [3];
    logic signed [DIFF_BITS-1:0]  v_reg [3];
    logic signed [PROD_BITS-1:0]  p_reg [6];
    logic [MAG_BITS-1:0]          mag_reg [3];
    logic [SQ_BITS-1:0]           sq_reg [3];
    logic [RAD_BITS-1:0]          rad_reg;

    logic signed [DIFF_BITS-1:0]  u_next [3];
    logic signed [DIFF_BITS-1:0]  v_next [3];
    logic [MAG_BITS-1:0]          mag_next [3];
    logic signed [CRS_BITS-1:0]   w_val;

    // Square-root unit.
    logic                 sqrt_start;
    logic                 sqrt_pending_reg;
    sqrt_stat_t           sqrt_stat;
    logic [ROOT_BITS-1:0] sqrt_root;

    // Running total and result registers.
    logic [TOTAL_BITS-1:0] total_reg, total_next;
    logic                  flag_reg, flag_next;
    logic                  done_reg;
    logic [TRI_BITS-1:0]   tri_reg;
    logic [TOTAL_BITS-1:0] base;
    logic [ACC_BITS-1:0]   acc_sum;

    assign accept  = start && (state_reg == S_IDLE);
    assign busy    = (state_reg != S_IDLE);
    assign slot_ok = (32'(vertex_slot) < 32'(VERTEX_DEPTH));

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (accept && req_type == REQ_TRIANGLE) state_next = S_RDA;
            S_RDA:   state_next = S_RDB;
            S_RDB:   state_next = S_RDC;
            S_RDC:   state_next = S_DIFF;
            S_DIFF:  state_next = S_MUL;
            S_MUL:   state_next = S_CROSS;
            S_CROSS: state_next = S_SQ;
            S_SQ:    state_next = S_SUM;
            S_SUM:   state_next = S_ROOT;
            S_ROOT:  if (sqrt_stat.done) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // The memory port reads one corner per cycle; reads and writes never overlap
    // because a vertex write is only taken while the sequencer is idle.
    always_comb
    begin
        unique case (state_reg)
            S_RDB:   rd_addr = cb_reg;
            S_RDC:   rd_addr = cc_reg;
            default: rd_addr = ca_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (accept && req_type == REQ_VERTEX && slot_ok)
            vstore[AW'(vertex_slot)] <= {coord_x, coord_y, coord_z};
        rd_data_reg <= vstore[rd_addr];
    end

    // Capture the triangle request. Corners past the store read as the origin.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ca_reg      <= AW'(corner_a);
            cb_reg      <= AW'(corner_b);
            cc_reg      <= AW'(corner_c);
            ok_a_reg    <= (32'(corner_a) < 32'(VERTEX_DEPTH));
            ok_b_reg    <= (32'(corner_b) < 32'(VERTEX_DEPTH));
            ok_c_reg    <= (32'(corner_c) < 32'(VERTEX_DEPTH));
            restart_reg <= restart;
        end
    end

    // Edge vectors u = A - C and v = B - C.
    assign vc = ok_c_reg ? rd_data_reg : '0;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            u_next[i] = DIFF_BITS'($signed(va_reg[(2-i)*C +: C]))
                      - DIFF_BITS'($signed(vc[(2-i)*C +: C]));
            v_next[i] = DIFF_BITS'($signed(vb_reg[(2-i)*C +: C]))
                      - DIFF_BITS'($signed(vc[(2-i)*C +: C]));
        end
    end

    // Cross product components and their magnitudes.
    always_comb
    begin
        w_val = '0;
        for (int i = 0; i < 3; i++)
        begin
            w_val = CRS_BITS'(p_reg[2*i]) - CRS_BITS'(p_reg[2*i+1]);
            mag_next[i] = w_val[CRS_BITS-1] ? MAG_BITS'(-w_val) : MAG_BITS'(w_val);
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_RDB)
            va_reg <= ok_a_reg ? rd_data_reg : '0;
        if (state_reg == S_RDC)
            vb_reg <= ok_b_reg ? rd_data_reg : '0;
        if (state_reg == S_DIFF)
        begin
            for (int i = 0; i < 3; i++)
            begin
                u_reg[i] <= u_next[i];
                v_reg[i] <= v_next[i];
            end
        end
        if (state_reg == S_MUL)
        begin
            p_reg[0] <= PROD_BITS'(u_reg[1] * v_reg[2]);
            p_reg[1] <= PROD_BITS'(u_reg[2] * v_reg[1]);
            p_reg[2] <= PROD_BITS'(u_reg[2] * v_reg[0]);
            p_reg[3] <= PROD_BITS'(u_reg[0] * v_reg[2]);
            p_reg[4] <= PROD_BITS'(u_reg[0] * v_reg[1]);
            p_reg[5] <= PROD_BITS'(u_reg[1] * v_reg[0]);
        end
        if (state_reg == S_CROSS)
        begin
            for (int i = 0; i < 3; i++)
                mag_reg[i] <= mag_next[i];
        end
        if (state_reg == S_SQ)
        begin
            for (int i = 0; i < 3; i++)
                sq_reg[i] <= mag_reg[i] * mag_reg[i];
        end
        if (state_reg == S_SUM)
            rad_reg <= RAD_BITS'(sq_reg[0]) + RAD_BITS'(sq_reg[1]) + RAD_BITS'(sq_reg[2]);
    end

    // The radicand register loads at the end of the sum state; the root unit
    // picks it up on the following edge.
    assign sqrt_start = (state_reg == S_ROOT) && !sqrt_stat.busy && !sqrt_stat.done
                        && !sqrt_pending_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sqrt_pending_reg <= 1'b0;
        else if (sqrt_start)
            sqrt_pending_reg <= 1'b1;
        else if (sqrt_stat.done)
            sqrt_pending_reg <= 1'b0;
    end

    msa_isqrt #(
        .OUT_BITS (ROOT_BITS)
    ) u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (rad_reg),
        .stat     (sqrt_stat),
        .root     (sqrt_root)
    );

    // Saturating accumulate. A restart clears the total and flag first.
    always_comb
    begin
        base    = restart_reg ? '0 : total_reg;
        acc_sum = ACC_BITS'(base) + ACC_BITS'(sqrt_root);
        if (acc_sum > ACC_BITS'(TOTAL_MAX))
        begin
            total_next = TOTAL_MAX;
            flag_next  = 1'b1;
        end
        else
        begin
            total_next = TOTAL_BITS'(acc_sum);
            flag_next  = restart_reg ? 1'b0 : flag_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg <= '0;
            flag_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (accept && req_type == REQ_VERTEX)
                done_reg <= 1'b1;
            else if (state_reg == S_ROOT && sqrt_stat.done)
            begin
                done_reg  <= 1'b1;
                total_reg <= total_next;
                flag_reg  <= flag_next;
            end
        end
    end

    // The per-triangle output clips while the total takes the full root.
    always_ff @(posedge clk)
    begin
        if (accept && req_type == REQ_VERTEX)
            tri_reg <= '0;
        else if (state_reg == S_ROOT && sqrt_stat.done)
            tri_reg <= (64'(sqrt_root) > 64'(TRI_MAX)) ? TRI_MAX : TRI_BITS'(sqrt_root);
    end

    assign done              = done_reg;
    assign tri_double_area   = tri_reg;
    assign total_double_area = total_reg;
    assign overflowed        = flag_reg;

    // A triangle item always keeps the block busy on the next cycle.
    a_tri_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && req_type == REQ_TRIANGLE) |=> busy)
        else $error("triangle accepted but block not busy");

    // The flag can only come up together with a result.
    a_flag_rise: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(overflowed) |-> done)
        else $error("overflow flag rose without a result");

    // While the flag is set the total sits at its maximum.
    a_flag_max: assert property (@(posedge clk) disable iff (!rst_n)
        overflowed |-> (total_double_area == TOTAL_MAX))
        else $error("flag set but total not saturated");

    // The root unit only finishes while the sequencer waits for it.
    a_root_state: assert property (@(posedge clk) disable iff (!rst_n)
        sqrt_stat.done |-> (state_reg == S_ROOT))
        else $error("square root finished outside its wait state");

    // A vertex item never blocks the request side.
    a_vertex_free: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && req_type == REQ_VERTEX) |=> (!busy && done))
        else $error("vertex item did not complete in one cycle");

endmodule

>>> tb/tb_mesh_surface_area_accumulator.sv
// Self-checking testbench for the mesh surface area accumulator, with directed and random items.
`timescale 1ns / 1ps

module tb_mesh_surface_area_accumulator;

    import msa_pkg::*;

    // The block runs with its default store depth, coordinate width and total width.
    // At the full total width the running total cannot reach its maximum within a run
    // of this length, so the saturating path is only exercised by the predictor logic.
    localparam int VERTEX_COUNT = 4096;
    localparam int COORD_W      = 12;
    localparam int TOTAL_W      = 48;
    localparam logic [63:0] TOTAL_MAX = (64'd1 << TOTAL_W) - 64'd1;

    // TRI_LATENCY stands for the time from accept to a triangle result; the tail wait
    // and the long gaps are sized from it with a margin.
    localparam int TRI_LATENCY = 2 * COORD_W + 13;
    localparam int QUIET_LIMIT = 1000;

    typedef struct {
        logic                       kind;
        logic [SLOT_BITS-1:0]       slot;
        logic signed [COORD_W-1:0]  x;
        logic signed [COORD_W-1:0]  y;
        logic signed [COORD_W-1:0]  z;
        logic [SLOT_BITS-1:0]       ca;
        logic [SLOT_BITS-1:0]       cb;
        logic [SLOT_BITS-1:0]       cc;
        logic                       clear_total;
    } mesh_req_t;

    typedef struct {
        logic [TRI_BITS-1:0] dbl_area;
        logic [TOTAL_W-1:0]  total;
        logic                sat;
    } area_result_t;

    logic                       clk;
    logic                       rst_n       = 1'b0;
    logic                       start       = 1'b0;
    logic                       busy;
    logic                       req_type    = REQ_VERTEX;
    logic [SLOT_BITS-1:0]       vertex_slot = '0;
    logic signed [COORD_W-1:0]  coord_x     = '0;
    logic signed [COORD_W-1:0]  coord_y     = '0;
    logic signed [COORD_W-1:0]  coord_z     = '0;
    logic [SLOT_BITS-1:0]       corner_a    = '0;
    logic [SLOT_BITS-1:0]       corner_b    = '0;
    logic [SLOT_BITS-1:0]       corner_c    = '0;
    logic                       restart     = 1'b0;
    logic                       done;
    logic [TRI_BITS-1:0]        tri_double_area;
    logic [TOTAL_W-1:0]         total_double_area;
    logic                       overflowed;

    // Our own copy of the block's state: the vertex store, the total and its flag.
    logic signed [COORD_W-1:0]  mesh_x [VERTEX_COUNT];
    logic signed [COORD_W-1:0]  mesh_y [VERTEX_COUNT];
    logic signed [COORD_W-1:0]  mesh_z [VERTEX_COUNT];
    logic [63:0]                area_total      = '0;
    logic                       total_saturated = 1'b0;

    // Slots that hold a vertex. Triangles only ever name these, since reading a
    // slot that was never written has no defined answer.
    bit                         slot_written [VERTEX_COUNT];
    logic [SLOT_BITS-1:0]       written_slots [$];

    area_result_t               expected_results [$];
    int                         error_count  = 0;
    int                         quiet_cycles = 0;
    bit                         idle_enabled = 1'b0;

    mesh_surface_area_accumulator #(
        .VERTEX_DEPTH (VERTEX_COUNT),
        .COORD_BITS   (COORD_W),
        .TOTAL_BITS   (TOTAL_W)
    ) u_top (
        .clk               (clk),
        .rst_n             (rst_n),
        .start             (start),
        .busy              (busy),
        .req_type          (req_type),
        .vertex_slot       (vertex_slot),
        .coord_x           (coord_x),
        .coord_y           (coord_y),
        .coord_z           (coord_z),
        .corner_a          (corner_a),
        .corner_b          (corner_b),
        .corner_c          (corner_c),
        .restart           (restart),
        .done              (done),
        .tri_double_area   (tri_double_area),
        .total_double_area (total_double_area),
        .overflowed        (overflowed)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Twice the area of triangle (a, b, c): the integer square root of the squared
    // length of (a - c) x (b - c). With 12-bit coordinates every cross component fits
    // easily in 64 bits, and so does the sum of their squares.
    function automatic logic [63:0] double_area_of(input logic [SLOT_BITS-1:0] a,
                                                   input logic [SLOT_BITS-1:0] b,
                                                   input logic [SLOT_BITS-1:0] c);
        longint      ux, uy, uz, vx, vy, vz, wx, wy, wz;
        logic [63:0] sum_sq;
        logic [63:0] root;
        logic [63:0] trial;
        ux = longint'(mesh_x[a]) - longint'(mesh_x[c]);
        uy = longint'(mesh_y[a]) - longint'(mesh_y[c]);
        uz = longint'(mesh_z[a]) - longint'(mesh_z[c]);
        vx = longint'(mesh_x[b]) - longint'(mesh_x[c]);
        vy = longint'(mesh_y[b]) - longint'(mesh_y[c]);
        vz = longint'(mesh_z[b]) - longint'(mesh_z[c]);
        wx = uy * vz - uz * vy;
        wy = uz * vx - ux * vz;
        wz = ux * vy - uy * vx;
        sum_sq = wx * wx + wy * wy + wz * wz;
        // Bit-by-bit root, most significant bit first; 32 bits cover any 64-bit input.
        root = '0;
        for (int k = 31; k >= 0; k--)
        begin
            trial = root | (64'd1 << k);
            if (trial * trial <= sum_sq)
                root = trial;
        end
        return root;
    endfunction

    // Applies one accepted item to our state and returns the result it must cause.
    function automatic area_result_t predict_item(input mesh_req_t r);
        area_result_t res;
        logic [63:0]  area;
        res.dbl_area = '0;
        if (r.kind == REQ_VERTEX)
        begin
            // Every 12-bit slot lies inside the 4096-entry store, so no write is dropped.
            mesh_x[r.slot] = r.x;
            mesh_y[r.slot] = r.y;
            mesh_z[r.slot] = r.z;
            if (!slot_written[r.slot])
            begin
                slot_written[r.slot] = 1'b1;
                written_slots.push_back(r.slot);
            end
        end
        else
        begin
            area = double_area_of(r.ca, r.cb, r.cc);
            if (r.clear_total)
            begin
                area_total      = '0;
                total_saturated = 1'b0;
            end
            // The total sticks at its maximum and the flag stays up until a restart.
            if (area > TOTAL_MAX - area_total)
            begin
                area_total      = TOTAL_MAX;
                total_saturated = 1'b1;
            end
            else
            begin
                area_total = area_total + area;
            end
            res.dbl_area = (area > TRI_MAX) ? TRI_MAX : area[TRI_BITS-1:0];
        end
        res.total = area_total[TOTAL_W-1:0];
        res.sat   = total_saturated;
        return res;
    endfunction

    function automatic logic signed [COORD_W-1:0] rand_coord(input bit narrow);
        int v;
        if (narrow)
            v = int'($urandom_range(128)) - 64;
        else
            v = int'($urandom_range(4095)) - 2048;
        return v[COORD_W-1:0];
    endfunction

    // Builders for the two item kinds. Fields the block does not use for the kind
    // carry random values, so that the block is seen to ignore them.
    function automatic mesh_req_t make_vertex(input logic [SLOT_BITS-1:0] slot,
                                              input logic signed [COORD_W-1:0] x,
                                              input logic signed [COORD_W-1:0] y,
                                              input logic signed [COORD_W-1:0] z,
                                              input logic clear_total);
        mesh_req_t r;
        r.kind        = REQ_VERTEX;
        r.slot        = slot;
        r.x           = x;
        r.y           = y;
        r.z           = z;
        r.ca          = SLOT_BITS'($urandom);
        r.cb          = SLOT_BITS'($urandom);
        r.cc          = SLOT_BITS'($urandom);
        r.clear_total = clear_total;
        return r;
    endfunction

    function automatic mesh_req_t make_triangle(input logic [SLOT_BITS-1:0] a,
                                                input logic [SLOT_BITS-1:0] b,
                                                input logic [SLOT_BITS-1:0] c,
                                                input logic clear_total);
        mesh_req_t r;
        r.kind        = REQ_TRIANGLE;
        r.slot        = SLOT_BITS'($urandom);
        r.x           = rand_coord(1'b0);
        r.y           = rand_coord(1'b0);
        r.z           = rand_coord(1'b0);
        r.ca          = a;
        r.cb          = b;
        r.cc          = c;
        r.clear_total = clear_total;
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        error_count++;
    endtask

    // Sends one item and returns at the edge that accepts it, with start still high.
    // The caller either sends the next item in the same step or lowers start, so
    // start never sees two assignments in one step. An optional gap in front of the
    // item puts random junk on req_type, vertex_slot, coord_x and restart while start
    // is low; long gaps let the next item arrive at any point of a triangle's run.
    task automatic send_item(input mesh_req_t r);
        int gap;
        if (idle_enabled && $urandom_range(99) < 30)
        begin
            gap = ($urandom_range(7) == 0) ? $urandom_range(TRI_LATENCY + 8, 1)
                                           : $urandom_range(3, 1);
            start       <= 1'b0;
            req_type    <= 1'($urandom);
            vertex_slot <= SLOT_BITS'($urandom);
            coord_x     <= rand_coord(1'b0);
            restart     <= 1'($urandom);
            repeat (gap) @(posedge clk);
        end
        start       <= 1'b1;
        req_type    <= r.kind;
        vertex_slot <= r.slot;
        coord_x     <= r.x;
        coord_y     <= r.y;
        coord_z     <= r.z;
        corner_a    <= r.ca;
        corner_b    <= r.cb;
        corner_c    <= r.cc;
        restart     <= r.clear_total;
        // busy read right after the edge still holds its value from before the edge.
        do
            @(posedge clk);
        while (busy);
        expected_results.push_back(predict_item(r));
    endtask

    // Lowers start and holds off until every expected result has come back.
    task automatic drain_results();
        start <= 1'b0;
        do
            @(posedge clk);
        while (expected_results.size() != 0);
    endtask

    // Writes vertices at four corners of the coordinate cube, the origin, a few
    // points on the main diagonal that the triangle test uses for collinear cases,
    // and one more point. The slot numbers toggle every index bit between them.
    task automatic test_vertex_extremes();
        send_item(make_vertex(12'd0,    -12'sd2048, -12'sd2048, -12'sd2048, 1'b0));
        send_item(make_vertex(12'd4095,  12'sd2047,  12'sd2047,  12'sd2047, 1'b0));
        send_item(make_vertex(12'd2730,  12'sd2047,  12'sd2047, -12'sd2048, 1'b0));
        send_item(make_vertex(12'd1365,  12'sd2047, -12'sd2048,  12'sd2047, 1'b0));
        send_item(make_vertex(12'd1,     12'sd0,     12'sd0,     12'sd0,    1'b0));
        send_item(make_vertex(12'd2,     12'sd1,     12'sd1,     12'sd1,    1'b0));
        send_item(make_vertex(12'd3,    -12'sd1,    -12'sd1,    -12'sd1,    1'b0));
        send_item(make_vertex(12'd4,    -12'sd2048,  12'sd2047,  12'sd0,    1'b0));
    endtask

    // Large, small and degenerate triangles: all corners on one line, all three
    // corners the same slot, and two corners repeated.
    task automatic test_triangle_shapes();
        send_item(make_triangle(12'd2730, 12'd1365, 12'd0,    1'b1));
        send_item(make_triangle(12'd0,    12'd4095, 12'd1,    1'b0));
        send_item(make_triangle(12'd1,    12'd2,    12'd3,    1'b0));
        send_item(make_triangle(12'd2,    12'd2,    12'd2,    1'b0));
        send_item(make_triangle(12'd1,    12'd1,    12'd4,    1'b0));
        send_item(make_triangle(12'd4095, 12'd0,    12'd2730, 1'b0));
        send_item(make_triangle(12'd4,    12'd2730, 12'd1365, 1'b0));
    endtask

    // A restart on a vertex write must leave the total and the flag alone.
    task automatic test_restart_on_vertex_write();
        send_item(make_vertex(12'd5, 12'sd100, -12'sd200, 12'sd300, 1'b1));
    endtask

    // Repeats the largest triangle so the total climbs in its biggest steps, and then
    // a restart clears the total and the flag before a small triangle is added.
    task automatic test_total_saturation();
        send_item(make_triangle(12'd2730, 12'd1365, 12'd0, 1'b1));
        repeat (5) send_item(make_triangle(12'd2730, 12'd1365, 12'd0, 1'b0));
        send_item(make_triangle(12'd1, 12'd4, 12'd5, 1'b1));
    endtask

    // Mesh-like traffic: vertex writes into random slots, some overwriting, mixed
    // with triangles whose corners are all written slots. Coordinates are either
    // full range or a small patch around the origin, so areas are sometimes large
    // and sometimes tiny. The first quarter runs back to back with no gaps,
    // and halfway through the sender waits until the block has drained.
    task automatic test_random_mesh(input int n_items);
        mesh_req_t            r;
        logic [SLOT_BITS-1:0] pick [3];
        logic [SLOT_BITS-1:0] slot;
        bit                   narrow;
        for (int i = 0; i < n_items; i++)
        begin
            idle_enabled = (i >= n_items / 4);
            if (i == n_items / 2)
                drain_results();
            if ($urandom_range(99) < 40)
            begin
                if ($urandom_range(4) == 0)
                    slot = written_slots[$urandom_range(written_slots.size() - 1)];
                else
                    slot = SLOT_BITS'($urandom);
                narrow = 1'($urandom);
                r = make_vertex(slot, rand_coord(narrow), rand_coord(narrow),
                                rand_coord(narrow), $urandom_range(7) == 0);
            end
            else
            begin
                for (int j = 0; j < 3; j++)
                    pick[j] = written_slots[$urandom_range(written_slots.size() - 1)];
                if ($urandom_range(9) == 0)
                    pick[$urandom_range(2)] = pick[$urandom_range(2)];
                r = make_triangle(pick[0], pick[1], pick[2], $urandom_range(9) == 0);
            end
            send_item(r);
        end
    endtask

    // Result checker: every strobe is matched against the oldest expectation.
    always @(posedge clk)
    begin : result_check
        area_result_t want;
        if (rst_n && done)
        begin
            if (expected_results.size() == 0)
            begin
                report_mismatch("result strobe with no item outstanding");
            end
            else
            begin
                want = expected_results.pop_front();
                if (tri_double_area !== want.dbl_area)
                    report_mismatch($sformatf("tri_double_area got %0d expected %0d",
                                              tri_double_area, want.dbl_area));
                if (total_double_area !== want.total)
                    report_mismatch($sformatf("total_double_area got %0d expected %0d",
                                              total_double_area, want.total));
                if (overflowed !== want.sat)
                    report_mismatch($sformatf("overflowed got %0b expected %0b",
                                              overflowed, want.sat));
            end
        end
    end

    // Watchdog: a long stretch with neither an accepted item nor a result means a hang.
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        idle_enabled = 1'b1;
        test_vertex_extremes();
        test_triangle_shapes();
        test_restart_on_vertex_write();
        test_total_saturation();
        test_random_mesh(850);

        drain_results();
        repeat (TRI_LATENCY + 10) @(posedge clk);
        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

>>> sim.f
rtl/msa_pkg.sv
rtl/msa_isqrt.sv
rtl/mesh_surface_area_accumulator.sv
tb/tb_mesh_surface_area_accumulator.sv
